// ===== src/tald_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tald_pkg
// Shared types and constants of the temperature alert light driver.
// ----------------------------------------------------------------------------
package tald_pkg;

  // elapsed-time counter width and its saturation value
  localparam int unsigned TimerBits = 16;
  localparam logic [TimerBits-1:0] TimerMax = {TimerBits{1'b1}};

  // field widths
  localparam int unsigned TempBits  = 11;
  localparam int unsigned IntvBits  = 16;
  localparam int unsigned CountBits = 4;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned InDataBits  = 16;
  localparam int unsigned OutDataBits = 8;

  // register indexes of the configuration port
  localparam logic [CfgIdxBits-1:0] CfgColdLimit     = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgHotLimit      = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgFlashHalf     = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgPulseGap      = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgPulseLength   = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgBurstPeriod   = 3'd5;
  localparam logic [CfgIdxBits-1:0] CfgPulsesPerBurst = 3'd6;

  // register reset values
  localparam logic signed [TempBits-1:0] ColdLimitRst = 11'sd200;
  localparam logic signed [TempBits-1:0] HotLimitRst  = 11'sd300;
  localparam logic [IntvBits-1:0]  FlashHalfRst     = 16'd200;
  localparam logic [IntvBits-1:0]  PulseGapRst      = 16'd400;
  localparam logic [IntvBits-1:0]  PulseLengthRst   = 16'd200;
  localparam logic [IntvBits-1:0]  BurstPeriodRst   = 16'd5000;
  localparam logic [CountBits-1:0] PulsesPerBurstRst = 4'd3;

  // item kinds carried in tuser
  localparam logic OpTick   = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef enum logic [1:0] {
    BandCold,
    BandMid,
    BandHot
  } band_e;

  typedef struct packed {
    logic signed [TempBits-1:0] cold_limit;
    logic signed [TempBits-1:0] hot_limit;
    logic [IntvBits-1:0]        flash_half_period;
    logic [IntvBits-1:0]        pulse_gap;
    logic [IntvBits-1:0]        pulse_length;
    logic [IntvBits-1:0]        burst_period;
    logic [CountBits-1:0]       pulses_per_burst;
  } cfg_t;

  typedef struct packed {
    logic alert;
    logic buzzer;
    logic blue_led;
    logic green_led;
    logic red_led;
  } pins_t;

endpackage

// ===== src/temperature_alert_light_driver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_alert_light_driver_core
// Drives RGB lights and a buzzer from millisecond ticks and temperature items.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while s_tready_o is high and returns one
// result per item: the item is held in an input register, the band compare
// and all state updates happen in one pass of logic, and the pin levels land
// in an output register. The output register and the input register each
// hold one item, so one more item is taken while a result waits for
// m_tready_i, after which s_tready_o drops until the result leaves.
// Configuration writes take effect at once and are meant for idle periods.
module temperature_alert_light_driver_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [tald_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [tald_pkg::CfgDataBits-1:0]    cfg_data_i,
  // input items
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [tald_pkg::InDataBits-1:0]     s_tdata_i,   // [10:0] temperature
  input  logic                                s_tuser_i,   // [0] opcode
  // result items
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  // [0] red_led, [1] green_led, [2] blue_led, [3] buzzer, [4] alert
  output logic [tald_pkg::OutDataBits-1:0]    m_tdata_o
);
  import tald_pkg::*;

  cfg_t cfg_q;

  logic                       in_valid_q;
  logic                       in_op_q;
  logic signed [TempBits-1:0] in_temp_q;

  logic  out_valid_q;
  pins_t out_pins_q;

  logic  proc_fire;
  band_e band;
  pins_t pins;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cold_limit        <= ColdLimitRst;
      cfg_q.hot_limit         <= HotLimitRst;
      cfg_q.flash_half_period <= FlashHalfRst;
      cfg_q.pulse_gap         <= PulseGapRst;
      cfg_q.pulse_length      <= PulseLengthRst;
      cfg_q.burst_period      <= BurstPeriodRst;
      cfg_q.pulses_per_burst  <= PulsesPerBurstRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgColdLimit:      cfg_q.cold_limit        <= cfg_data_i[TempBits-1:0];
        CfgHotLimit:       cfg_q.hot_limit         <= cfg_data_i[TempBits-1:0];
        CfgFlashHalf:      cfg_q.flash_half_period <= cfg_data_i[IntvBits-1:0];
        CfgPulseGap:       cfg_q.pulse_gap         <= cfg_data_i[IntvBits-1:0];
        CfgPulseLength:    cfg_q.pulse_length      <= cfg_data_i[IntvBits-1:0];
        CfgBurstPeriod:    cfg_q.burst_period      <= cfg_data_i[IntvBits-1:0];
        CfgPulsesPerBurst: cfg_q.pulses_per_burst  <= cfg_data_i[CountBits-1:0];
        default:           cfg_q                   <= cfg_q;
      endcase
    end
  end

  // handshake: process when the output slot is free or being emptied
  assign proc_fire  = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || proc_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      in_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_op_q   <= s_tuser_i;
      in_temp_q <= s_tdata_i[TempBits-1:0];
    end
  end

  tald_band u_band (
    .temperature_i (in_temp_q),
    .cfg_i         (cfg_q),
    .band_o        (band)
  );

  tald_alert u_alert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (proc_fire),
    .is_sample_i (in_op_q == OpSample),
    .band_i      (band),
    .cfg_i       (cfg_q),
    .pins_o      (pins)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_pins_q <= pins;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OutDataBits - $bits(pins_t)){1'b0}}, out_pins_q};

endmodule

// ===== src/tald_band.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tald_band
// Sorts a temperature sample into the cold, mid or hot band.
// ----------------------------------------------------------------------------
module tald_band (
  input  logic signed [tald_pkg::TempBits-1:0] temperature_i,
  input  tald_pkg::cfg_t                       cfg_i,
  output tald_pkg::band_e                      band_o
);
  import tald_pkg::*;

  // cold is tested first, so crossed limits leave the mid band empty
  always_comb begin
    priority if (temperature_i < cfg_i.cold_limit) begin
      band_o = BandCold;
    end else if (temperature_i < cfg_i.hot_limit) begin
      band_o = BandMid;
    end else begin
      band_o = BandHot;
    end
  end

endmodule

// ===== src/tald_alert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tald_alert
// Light, flash and buzzer state; advances once per processed item.
// ----------------------------------------------------------------------------
module tald_alert (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            is_sample_i,
  input  tald_pkg::band_e band_i,
  input  tald_pkg::cfg_t  cfg_i,
  output tald_pkg::pins_t pins_o
);
  import tald_pkg::*;

  // compare width covers both the timers and the interval registers
  localparam int unsigned CmpBits = (TimerBits > IntvBits) ? TimerBits : IntvBits;

  logic alert_q, alert_d;
  logic red_phase_q, red_phase_d;
  logic red_pin_q, red_pin_d;
  logic green_pin_q, green_pin_d;
  logic blue_pin_q, blue_pin_d;
  logic buzzer_pin_q, buzzer_pin_d;
  logic buzz_phase_q, buzz_phase_d;
  logic [CountBits-1:0] pulse_count_q, pulse_count_d;
  logic [TimerBits-1:0] flash_q, flash_d;
  logic [TimerBits-1:0] buzz_q, buzz_d;
  logic [TimerBits-1:0] burst_q, burst_d;

  // next state for one item
  always_comb begin
    alert_d       = alert_q;
    red_phase_d   = red_phase_q;
    red_pin_d     = red_pin_q;
    green_pin_d   = green_pin_q;
    blue_pin_d    = blue_pin_q;
    buzzer_pin_d  = buzzer_pin_q;
    buzz_phase_d  = buzz_phase_q;
    pulse_count_d = pulse_count_q;
    flash_d       = flash_q;
    buzz_d        = buzz_q;
    burst_d       = burst_q;

    // tick advances the saturating timers, a sample applies its band
    if (!is_sample_i) begin
      flash_d = (flash_q == TimerMax) ? flash_q : flash_q + 1'b1;
      buzz_d  = (buzz_q == TimerMax) ? buzz_q : buzz_q + 1'b1;
      burst_d = (burst_q == TimerMax) ? burst_q : burst_q + 1'b1;
    end else begin
      unique case (band_i)
        BandCold: begin
          blue_pin_d  = 1'b1;
          green_pin_d = 1'b0;
          red_pin_d   = 1'b0;
          alert_d     = 1'b0;
        end
        BandMid: begin
          blue_pin_d  = 1'b0;
          green_pin_d = 1'b1;
          red_pin_d   = 1'b0;
        end
        BandHot: begin
          // restart: red and buzzer pins keep their levels
          blue_pin_d    = 1'b0;
          green_pin_d   = 1'b0;
          alert_d       = 1'b1;
          flash_d       = '0;
          buzz_d        = '0;
          burst_d       = '0;
          pulse_count_d = '0;
          buzz_phase_d  = 1'b0;
          red_phase_d   = 1'b0;
        end
        default: begin
          blue_pin_d = blue_pin_q;
        end
      endcase
    end

    // flashing and buzzer bursts while the alert is on
    if (alert_d) begin
      if (CmpBits'(flash_d) >= CmpBits'(cfg_i.flash_half_period)) begin
        flash_d     = '0;
        red_phase_d = !red_phase_d;
        red_pin_d   = red_phase_d;
      end
      if (pulse_count_d < cfg_i.pulses_per_burst) begin
        priority if (!buzz_phase_d &&
                     CmpBits'(buzz_d) >= CmpBits'(cfg_i.pulse_gap)) begin
          buzz_phase_d = 1'b1;
          buzz_d       = '0;
          buzzer_pin_d = 1'b1;
        end else if (buzz_phase_d &&
                     CmpBits'(buzz_d) >= CmpBits'(cfg_i.pulse_length)) begin
          buzz_phase_d  = 1'b0;
          buzz_d        = '0;
          buzzer_pin_d  = 1'b0;
          pulse_count_d = pulse_count_d + 1'b1;
        end
      end else if (CmpBits'(burst_d) >= CmpBits'(cfg_i.burst_period)) begin
        pulse_count_d = '0;
        burst_d       = '0;
      end
    end else begin
      buzzer_pin_d = 1'b0;
      red_pin_d    = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alert_q       <= 1'b0;
      red_phase_q   <= 1'b0;
      red_pin_q     <= 1'b0;
      green_pin_q   <= 1'b0;
      blue_pin_q    <= 1'b0;
      buzzer_pin_q  <= 1'b0;
      buzz_phase_q  <= 1'b0;
      pulse_count_q <= '0;
      flash_q       <= '0;
      buzz_q        <= '0;
      burst_q       <= '0;
    end else if (en_i) begin
      alert_q       <= alert_d;
      red_phase_q   <= red_phase_d;
      red_pin_q     <= red_pin_d;
      green_pin_q   <= green_pin_d;
      blue_pin_q    <= blue_pin_d;
      buzzer_pin_q  <= buzzer_pin_d;
      buzz_phase_q  <= buzz_phase_d;
      pulse_count_q <= pulse_count_d;
      flash_q       <= flash_d;
      buzz_q        <= buzz_d;
      burst_q       <= burst_d;
    end
  end

  // levels after this item
  assign pins_o = '{alert:     alert_d,
                    buzzer:    buzzer_pin_d,
                    blue_led:  blue_pin_d,
                    green_led: green_pin_d,
                    red_led:   red_pin_d};

  // red and buzzer are low whenever the alert is off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !alert_q |-> (!red_pin_q && !buzzer_pin_q))
    else $error("red or buzzer driven without alert");

  // blue and green never light together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(blue_pin_q && green_pin_q))
    else $error("blue and green both lit");

  // a hot sample always leaves the alert on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && is_sample_i && band_i == BandHot) |=> alert_q)
    else $error("hot sample did not raise alert");

  // timers only move when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(flash_q) && $stable(buzz_q) && $stable(burst_q)))
    else $error("timer moved without an item");

endmodule

// ===== tb/sv/tald_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tald_checker
// Watches the config port and both item channels of the temperature alert
// light driver, predicts the pin levels of every accepted item with its own
// copy of the driver state, and compares each accepted result in order.
// ----------------------------------------------------------------------------
module tald_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tald_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [tald_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [tald_pkg::InDataBits-1:0]  s_tdata_i,   // [10:0] temperature
  input  logic                             s_tuser_i,   // [0] opcode
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  // [0] red_led, [1] green_led, [2] blue_led, [3] buzzer, [4] alert
  input  logic [tald_pkg::OutDataBits-1:0] m_tdata_i,
  output int unsigned                      fail_cnt_o,
  output int unsigned                      pending_o,
  output int unsigned                      checked_o
);
  import tald_pkg::*;

  localparam int unsigned PinBits = $bits(pins_t);

  typedef struct packed {
    logic                 alert_on;
    logic                 red_phase;
    logic                 red_pin;
    logic                 green_pin;
    logic                 blue_pin;
    logic                 buzzer_pin;
    logic                 buzz_phase;
    logic [CountBits-1:0] pulse_count;
    logic [TimerBits-1:0] flash_ms;
    logic [TimerBits-1:0] buzz_ms;
    logic [TimerBits-1:0] burst_ms;
  } lamp_state_t;

  cfg_t        settings;
  lamp_state_t lamp;
  pins_t       expected_pins[$];

  // elapsed counters hold at their top value
  function automatic logic [TimerBits-1:0] bump(input logic [TimerBits-1:0] c);
    return (c == TimerMax) ? c : c + 1'b1;
  endfunction

  // cold is tested first, so crossed limits leave no mid band
  function automatic band_e classify(input logic signed [TempBits-1:0] t);
    if (t < settings.cold_limit) return BandCold;
    if (t < settings.hot_limit) return BandMid;
    return BandHot;
  endfunction

  // advance the driver state by one item and return the pin levels after it
  function automatic pins_t next_pins(input logic op, input logic signed [TempBits-1:0] t);
    pins_t p;
    if (op == OpTick) begin
      lamp.flash_ms = bump(lamp.flash_ms);
      lamp.buzz_ms  = bump(lamp.buzz_ms);
      lamp.burst_ms = bump(lamp.burst_ms);
    end else begin
      case (classify(t))
        BandCold: begin
          lamp.blue_pin  = 1'b1;
          lamp.green_pin = 1'b0;
          lamp.red_pin   = 1'b0;
          lamp.alert_on  = 1'b0;
        end
        BandMid: begin
          lamp.blue_pin  = 1'b0;
          lamp.green_pin = 1'b1;
          lamp.red_pin   = 1'b0;
        end
        default: begin
          // restart: red and buzzer pins keep their levels
          lamp.blue_pin    = 1'b0;
          lamp.green_pin   = 1'b0;
          lamp.alert_on    = 1'b1;
          lamp.flash_ms    = '0;
          lamp.buzz_ms     = '0;
          lamp.burst_ms    = '0;
          lamp.pulse_count = '0;
          lamp.buzz_phase  = 1'b0;
          lamp.red_phase   = 1'b0;
        end
      endcase
    end

    if (lamp.alert_on) begin
      // red flashing
      if (lamp.flash_ms >= settings.flash_half_period) begin
        lamp.flash_ms  = '0;
        lamp.red_phase = !lamp.red_phase;
        lamp.red_pin   = lamp.red_phase;
      end
      // buzzer bursts
      if (lamp.pulse_count < settings.pulses_per_burst) begin
        if (!lamp.buzz_phase && lamp.buzz_ms >= settings.pulse_gap) begin
          lamp.buzz_phase = 1'b1;
          lamp.buzz_ms    = '0;
          lamp.buzzer_pin = 1'b1;
        end else if (lamp.buzz_phase && lamp.buzz_ms >= settings.pulse_length) begin
          lamp.buzz_phase  = 1'b0;
          lamp.buzz_ms     = '0;
          lamp.buzzer_pin  = 1'b0;
          lamp.pulse_count = lamp.pulse_count + 1'b1;
        end
      end else if (lamp.burst_ms >= settings.burst_period) begin
        lamp.pulse_count = '0;
        lamp.burst_ms    = '0;
      end
    end else begin
      lamp.buzzer_pin = 1'b0;
      lamp.red_pin    = 1'b0;
    end

    p.alert     = lamp.alert_on;
    p.buzzer    = lamp.buzzer_pin;
    p.blue_led  = lamp.blue_pin;
    p.green_led = lamp.green_pin;
    p.red_led   = lamp.red_pin;
    return p;
  endfunction

  task automatic check_field(input string field, input logic [OutDataBits-1:0] want,
                             input logic [OutDataBits-1:0] got);
    if (got !== want) begin
      fail_cnt_o++;
      $display("%0t ns: %s mismatch in result %0d: expected %0h, actual %0h",
               $time, field, checked_o, want, got);
    end
  endtask

  // config writes, then result compare, then prediction of the new item
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pins_t got;
    pins_t want;
    if (!rst_ni) begin
      settings.cold_limit        = ColdLimitRst;
      settings.hot_limit         = HotLimitRst;
      settings.flash_half_period = FlashHalfRst;
      settings.pulse_gap         = PulseGapRst;
      settings.pulse_length      = PulseLengthRst;
      settings.burst_period      = BurstPeriodRst;
      settings.pulses_per_burst  = PulsesPerBurstRst;
      lamp = '0;
      expected_pins.delete();
      fail_cnt_o = 0;
      checked_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgColdLimit:      settings.cold_limit        = cfg_data_i[TempBits-1:0];
          CfgHotLimit:       settings.hot_limit         = cfg_data_i[TempBits-1:0];
          CfgFlashHalf:      settings.flash_half_period = cfg_data_i[IntvBits-1:0];
          CfgPulseGap:       settings.pulse_gap         = cfg_data_i[IntvBits-1:0];
          CfgPulseLength:    settings.pulse_length      = cfg_data_i[IntvBits-1:0];
          CfgBurstPeriod:    settings.burst_period      = cfg_data_i[IntvBits-1:0];
          CfgPulsesPerBurst: settings.pulses_per_burst  = cfg_data_i[CountBits-1:0];
          default: ;
        endcase
      end

      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[PinBits-1:0];
        if (expected_pins.size() == 0) begin
          fail_cnt_o++;
          $display("%0t ns: unexpected result, expected none, actual %0h", $time, m_tdata_i);
        end else begin
          want = expected_pins.pop_front();
          check_field("red_led", OutDataBits'(want.red_led), OutDataBits'(got.red_led));
          check_field("green_led", OutDataBits'(want.green_led),
                      OutDataBits'(got.green_led));
          check_field("blue_led", OutDataBits'(want.blue_led), OutDataBits'(got.blue_led));
          check_field("buzzer", OutDataBits'(want.buzzer), OutDataBits'(got.buzzer));
          check_field("alert", OutDataBits'(want.alert), OutDataBits'(got.alert));
          check_field("padding", '0, OutDataBits'(m_tdata_i[OutDataBits-1:PinBits]));
          checked_o++;
        end
      end

      if (s_tvalid_i && s_tready_i)
        expected_pins.push_back(next_pins(s_tuser_i, $signed(s_tdata_i[TempBits-1:0])));
    end
    pending_o = expected_pins.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for temperature_alert_light_driver_core: directed
// band edges and alert sequences, then random phases of ticks and samples
// under changing register settings, including zero and widest intervals.
// ----------------------------------------------------------------------------
module tb;
  import tald_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 55;
  localparam int unsigned NumPhases  = 24;
  // index past the last register, ignored by the block
  localparam logic [CfgIdxBits-1:0] CfgSpare = 3'd7;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  logic                   s_tvalid_i;
  logic                   s_tready_o;
  logic [InDataBits-1:0]  s_tdata_i;   // [10:0] temperature
  logic                   s_tuser_i;   // [0] opcode
  logic                   m_tvalid_o;
  logic                   m_tready_i;
  // [0] red_led, [1] green_led, [2] blue_led, [3] buzzer, [4] alert
  logic [OutDataBits-1:0] m_tdata_o;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;
  int unsigned items_sent;
  int unsigned settings_used;
  int unsigned cycles;
  int unsigned stall_left;
  bit          quiet;
  cfg_t        cur_cfg;

  temperature_alert_light_driver_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  tald_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_i (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_i (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_i  (m_tdata_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side back-pressure in bursts of random length
  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      m_tready_i <= 1'b0;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      m_tready_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 4);
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  // one item on the input channel, with an occasional idle burst first
  task automatic push_item(input logic op, input logic signed [TempBits-1:0] t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= op;
    s_tdata_i  <= {{(InDataBits-TempBits){1'b0}}, t};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // tick items carry random, ignored temperature bits
  task automatic send_tick();
    push_item(OpTick, TempBits'($urandom_range(0, 2047)));
  endtask

  task automatic send_sample(input int t);
    push_item(OpSample, TempBits'(t));
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain();
    s_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
  endtask

  // write all registers while the block is idle
  task automatic apply_cfg(input cfg_t c);
    cfg_write(CfgColdLimit, CfgDataBits'(c.cold_limit));
    cfg_write(CfgHotLimit, CfgDataBits'(c.hot_limit));
    cfg_write(CfgFlashHalf, c.flash_half_period);
    cfg_write(CfgPulseGap, c.pulse_gap);
    cfg_write(CfgPulseLength, c.pulse_length);
    cfg_write(CfgBurstPeriod, c.burst_period);
    cfg_write(CfgPulsesPerBurst, CfgDataBits'(c.pulses_per_burst));
    cfg_write(CfgSpare, CfgDataBits'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  // short intervals so flashing and bursts happen within a phase;
  // extreme settings use only the ends of each register range
  function automatic cfg_t random_cfg(input bit extreme);
    cfg_t c;
    if (extreme) begin
      c.cold_limit        = $urandom_range(0, 1) ? 11'sh3FF : 11'sh400;
      c.hot_limit         = $urandom_range(0, 1) ? 11'sh3FF : 11'sh400;
      c.flash_half_period = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      c.pulse_gap         = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      c.pulse_length      = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      c.burst_period      = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      c.pulses_per_burst  = $urandom_range(0, 1) ? 4'hF : 4'h0;
    end else begin
      c.cold_limit = TempBits'(int'($urandom_range(0, 800)) - 400);
      if ($urandom_range(0, 5) == 0)
        c.hot_limit = TempBits'(int'(c.cold_limit) - int'($urandom_range(1, 200)));
      else
        c.hot_limit = TempBits'(int'(c.cold_limit) + int'($urandom_range(0, 300)));
      c.flash_half_period = IntvBits'($urandom_range(0, 6));
      c.pulse_gap         = IntvBits'($urandom_range(0, 5));
      c.pulse_length      = IntvBits'($urandom_range(0, 5));
      c.burst_period      = IntvBits'($urandom_range(0, 40));
      c.pulses_per_burst  = ($urandom_range(0, 3) == 0) ? CountBits'($urandom_range(0, 15))
                                                        : CountBits'($urandom_range(0, 4));
    end
    return c;
  endfunction

  // mostly ticks, samples clustered on the band edges
  task automatic run_phase(input int unsigned n);
    int hot_t;
    hot_t = (cur_cfg.cold_limit > cur_cfg.hot_limit) ? cur_cfg.cold_limit : cur_cfg.hot_limit;
    if ($urandom_range(0, 9) < 7) send_sample(hot_t);
    repeat (n) begin
      if ($urandom_range(0, 99) < 80) begin
        send_tick();
      end else begin
        case ($urandom_range(0, 5))
          0: send_sample(int'(cur_cfg.cold_limit) - 1);
          1: send_sample(cur_cfg.cold_limit);
          2: send_sample(int'(cur_cfg.hot_limit) - 1);
          3: send_sample(cur_cfg.hot_limit);
          4: send_sample(hot_t);
          default: send_sample($urandom_range(0, 2047));
        endcase
      end
    end
  endtask

  initial begin
    cfg_t c;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_tvalid_i    = 1'b0;
    s_tdata_i     = '0;
    s_tuser_i     = OpTick;
    m_tready_i    = 1'b1;
    quiet         = 1'b0;
    stall_left    = 0;
    cycles        = 0;
    items_sent    = 0;
    settings_used = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: just below cold, then hot
    send_sample(199);
    send_sample(300);
    drain();

    // directed: band edges, field extremes, restart and mid during alert
    c.cold_limit        = 11'sd100;
    c.hot_limit         = 11'sd300;
    c.flash_half_period = 16'd2;
    c.pulse_gap         = 16'd1;
    c.pulse_length      = 16'd2;
    c.burst_period      = 16'd12;
    c.pulses_per_burst  = 4'd2;
    apply_cfg(c);
    send_sample(-1024);
    send_sample(1023);
    repeat (6) send_tick();
    send_sample(200);
    repeat (3) send_tick();
    send_sample(99);
    send_sample(100);
    send_sample(299);
    send_sample(300);
    repeat (2) send_tick();
    send_sample(300);
    send_tick();
    send_sample(-400);
    send_sample(800);
    drain();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 4) quiet <= 1'b1;
      apply_cfg(random_cfg(p % 6 == 5));
      run_phase(PhaseItems);
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d items and %0d checked results under %0d register settings,",
             items_sent, checked, settings_used);
    $display("with band edges, crossed limits, zero and widest intervals, alert restarts");
    if (fail_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tald_pkg.sv
src/tald_band.sv
src/tald_alert.sv
src/temperature_alert_light_driver_core.sv
tb/sv/tald_checker.sv
tb/sv/tb.sv
